/* rtl/core/rbs_pkg.sv */
// Shared constants and types for the ray/box slab test.
// No dependencies.
`timescale 1ns / 1ps

package rbs_pkg;

    localparam int AXES           = 3;
    localparam int COORD_W        = 32;
    localparam int FRAC_W         = 16;
    // |corner - origin| fits 32 bits unsigned, scaled by 2^16
    localparam int NUM_W          = COORD_W + FRAC_W;
    localparam int BITS_PER_STAGE = 4;

    typedef struct packed {
        logic            valid;
        logic [AXES-1:0] neg_a;
        logic [AXES-1:0] neg_b;
        logic [AXES-1:0] dzero;
        logic [AXES-1:0] in_slab;
    } t_sband;

endpackage

/* rtl/core/rbs_div.sv */
// Pipelined unsigned restoring divider, a few quotient bits per stage.
// Depends on rbs_pkg for default widths.
`timescale 1ns / 1ps

module rbs_div
    import rbs_pkg::*;
#(
    parameter int NUM_BITS = NUM_W,
    parameter int DEN_BITS = COORD_W,
    parameter int BPS      = BITS_PER_STAGE
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic [NUM_BITS-1:0] o_quo
);

    localparam int STAGES = NUM_BITS / BPS;

    logic [DEN_BITS:0]   r_rem [STAGES];
    logic [NUM_BITS-1:0] r_num [STAGES]; // dividend bits out the top, quotient in the bottom
    logic [DEN_BITS-1:0] r_den [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic [DEN_BITS:0]   p_rem;
        logic [NUM_BITS-1:0] p_num;
        logic [DEN_BITS-1:0] p_den;
        logic [DEN_BITS:0]   n_rem;
        logic [NUM_BITS-1:0] n_num;

        if (g == 0) begin : g_first
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_den = i_den;
        end else begin : g_next
            assign p_rem = r_rem[g-1];
            assign p_num = r_num[g-1];
            assign p_den = r_den[g-1];
        end

        always_comb begin
            n_rem = p_rem;
            n_num = p_num;
            for (int k = 0; k < BPS; k++) begin
                n_rem = {n_rem[DEN_BITS-1:0], n_num[NUM_BITS-1]};
                n_num = {n_num[NUM_BITS-2:0], 1'b0};
                if (n_rem >= {1'b0, p_den}) begin
                    n_rem    = n_rem - {1'b0, p_den};
                    n_num[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_num[g] <= n_num;
                r_den[g] <= p_den;
            end
        end
    end

    assign o_quo = r_num[STAGES-1];

endmodule

/* rtl/core/ray_box_slab_test.sv */
// Ray versus axis-aligned box hit test, slab method, signed Q16.16.
// One beat per cycle while the output is not stalled.
// The six pipelined dividers each take one item a cycle unless the output stalls.
// A stall with o_valid high freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
// Depends on rbs_pkg and rbs_div.
`timescale 1ns / 1ps

module ray_box_slab_test
    import rbs_pkg::*;
#(
    parameter int DIV_BITS_PER_STAGE = BITS_PER_STAGE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic signed [31:0] i_box_lo_x,
    input  logic signed [31:0] i_box_lo_y,
    input  logic signed [31:0] i_box_lo_z,
    input  logic signed [31:0] i_box_hi_x,
    input  logic signed [31:0] i_box_hi_y,
    input  logic signed [31:0] i_box_hi_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit
);

    localparam int STAGES = NUM_W / DIV_BITS_PER_STAGE;
    localparam int TW     = NUM_W + 1;
    localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};
    localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic signed [COORD_W-1:0] c_o [AXES];
    logic signed [COORD_W-1:0] c_d [AXES];
    logic signed [COORD_W-1:0] c_a [AXES];
    logic signed [COORD_W-1:0] c_b [AXES];

    assign c_o[0] = i_origin_x;  assign c_o[1] = i_origin_y;  assign c_o[2] = i_origin_z;
    assign c_d[0] = i_dir_x;     assign c_d[1] = i_dir_y;     assign c_d[2] = i_dir_z;
    assign c_a[0] = i_box_lo_x;  assign c_a[1] = i_box_lo_y;  assign c_a[2] = i_box_lo_z;
    assign c_b[0] = i_box_hi_x;  assign c_b[1] = i_box_hi_y;  assign c_b[2] = i_box_hi_z;

    // stage 1: differences, magnitudes, signs, zero-direction checks
    logic [NUM_W-1:0]   r_num_a [AXES];
    logic [NUM_W-1:0]   r_num_b [AXES];
    logic [COORD_W-1:0] r_den   [AXES];
    t_sband             r_s1;
    t_sband             n_s1;
    logic [NUM_W-1:0]   n_num_a [AXES];
    logic [NUM_W-1:0]   n_num_b [AXES];
    logic [COORD_W-1:0] n_den   [AXES];

    always_comb begin
        logic signed [COORD_W:0] da;
        logic signed [COORD_W:0] db;
        logic [COORD_W:0]        ma;
        logic [COORD_W:0]        mb;
        logic [COORD_W-1:0]      md;
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        n_s1.valid = i_valid;
        for (int k = 0; k < AXES; k++) begin
            da = $signed({c_a[k][COORD_W-1], c_a[k]}) - $signed({c_o[k][COORD_W-1], c_o[k]});
            db = $signed({c_b[k][COORD_W-1], c_b[k]}) - $signed({c_o[k][COORD_W-1], c_o[k]});
            ma = da[COORD_W] ? -da : da;
            mb = db[COORD_W] ? -db : db;
            md = c_d[k][COORD_W-1] ? -c_d[k] : c_d[k];
            n_num_a[k]     = {ma[COORD_W-1:0], {FRAC_W{1'b0}}};
            n_num_b[k]     = {mb[COORD_W-1:0], {FRAC_W{1'b0}}};
            n_den[k]       = md;
            n_s1.neg_a[k]  = da[COORD_W] ^ c_d[k][COORD_W-1];
            n_s1.neg_b[k]  = db[COORD_W] ^ c_d[k][COORD_W-1];
            n_s1.dzero[k]  = (c_d[k] == '0);
            lo = (c_a[k] < c_b[k]) ? c_a[k] : c_b[k];
            hi = (c_a[k] < c_b[k]) ? c_b[k] : c_a[k];
            n_s1.in_slab[k] = (c_o[k] >= lo) && (c_o[k] <= hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (en) begin
            r_s1 <= n_s1;
        end
        if (en) begin
            r_num_a <= n_num_a;
            r_num_b <= n_num_b;
            r_den   <= n_den;
        end
    end

    // dividers, sideband follows alongside
    logic [NUM_W-1:0] w_q_a [AXES];
    logic [NUM_W-1:0] w_q_b [AXES];

    for (genvar k = 0; k < AXES; k++) begin : g_axis
        rbs_div #(.NUM_BITS(NUM_W), .DEN_BITS(COORD_W), .BPS(DIV_BITS_PER_STAGE)) u_div_a (
            .i_clk (i_clk), .i_en (en), .i_num (r_num_a[k]), .i_den (r_den[k]),
            .o_quo (w_q_a[k])
        );
        rbs_div #(.NUM_BITS(NUM_W), .DEN_BITS(COORD_W), .BPS(DIV_BITS_PER_STAGE)) u_div_b (
            .i_clk (i_clk), .i_en (en), .i_num (r_num_b[k]), .i_den (r_den[k]),
            .o_quo (w_q_b[k])
        );
    end

    t_sband r_sb [STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) r_sb[s] <= '0;
        end else if (en) begin
            r_sb[0] <= r_s1;
            for (int s = 1; s < STAGES; s++) r_sb[s] <= r_sb[s-1];
        end
    end

    // stage 2: signed distances, near/far per axis
    logic signed [TW-1:0] r_near [AXES];
    logic signed [TW-1:0] r_far  [AXES];
    logic                 r_v2;
    logic                 r_ok2;
    logic signed [TW-1:0] n_near [AXES];
    logic signed [TW-1:0] n_far  [AXES];
    logic                 n_ok2;

    always_comb begin
        logic signed [TW-1:0] t1;
        logic signed [TW-1:0] t2;
        t_sband sb;
        sb    = r_sb[STAGES-1];
        n_ok2 = 1'b1;
        for (int k = 0; k < AXES; k++) begin
            t1 = sb.neg_a[k] ? -$signed({1'b0, w_q_a[k]}) : $signed({1'b0, w_q_a[k]});
            t2 = sb.neg_b[k] ? -$signed({1'b0, w_q_b[k]}) : $signed({1'b0, w_q_b[k]});
            if (sb.dzero[k]) begin
                n_near[k] = T_MIN;
                n_far[k]  = T_MAX;
                n_ok2     = n_ok2 & sb.in_slab[k];
            end else begin
                n_near[k] = (t1 < t2) ? t1 : t2;
                n_far[k]  = (t1 < t2) ? t2 : t1;
            end
        end
    end

    // stage 3: entry and exit
    logic signed [TW-1:0] r_entry;
    logic signed [TW-1:0] r_exit;
    logic                 r_v3;
    logic                 r_ok3;
    logic signed [TW-1:0] n_entry;
    logic signed [TW-1:0] n_exit;

    always_comb begin
        n_entry = r_near[0];
        n_exit  = r_far[0];
        for (int k = 1; k < AXES; k++) begin
            if (r_near[k] > n_entry) n_entry = r_near[k];
            if (r_far[k] < n_exit)   n_exit  = r_far[k];
        end
    end

    // stage 4: output register
    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v2    <= r_sb[STAGES-1].valid;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
        if (en) begin
            r_near  <= n_near;
            r_far   <= n_far;
            r_ok2   <= n_ok2;
            r_entry <= n_entry;
            r_exit  <= n_exit;
            r_ok3   <= r_ok2;
            r_hit   <= r_ok3 && !(r_exit < 0) && !(r_entry > r_exit);
        end
    end

    assign o_hit = r_hit;

endmodule

/* test/tb.sv */
// Self-checking bench for ray_box_slab_test: slab hit prediction with a scoreboard class.
// Depends on rbs_pkg and the ray_box_slab_test RTL.
`timescale 1ns / 1ps

module tb;
    import rbs_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LATENCY      = 16;
    localparam int N_RANDOM     = 1430;

    typedef struct {
        logic signed [31:0] o [3];
        logic signed [31:0] d [3];
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
    } t_ray;

    class hit_board;
        bit   hit_q [$];
        int   errors;
        int   n_hits;
        int   n_checked;

        function bit predict_hit(t_ray r);
            longint entry_t, exit_t, t1, t2, lo, hi, ov;
            bit ok;
            entry_t = 64'sh8000_0000_0000_0000;
            exit_t  = 64'sh7fff_ffff_ffff_ffff;
            ok = 1;
            for (int k = 0; k < 3; k++) begin
                ov = longint'(r.o[k]);
                if (r.d[k] == 0) begin
                    lo = (r.a[k] < r.b[k]) ? r.a[k] : r.b[k];
                    hi = (r.a[k] < r.b[k]) ? r.b[k] : r.a[k];
                    if (ov < lo || ov > hi) ok = 0;
                end else begin
                    t1 = ((longint'(r.a[k]) - ov) * 65536) / longint'(r.d[k]);
                    t2 = ((longint'(r.b[k]) - ov) * 65536) / longint'(r.d[k]);
                    if (t1 > t2) begin
                        lo = t2; hi = t1;
                    end else begin
                        lo = t1; hi = t2;
                    end
                    if (lo > entry_t) entry_t = lo;
                    if (hi < exit_t) exit_t = hi;
                end
            end
            if (exit_t < 0 || entry_t > exit_t) ok = 0;
            return ok;
        endfunction

        function void note_ray(t_ray r);
            hit_q.push_back(predict_hit(r));
        endfunction

        function void check_hit(logic got);
            bit want;
            n_checked++;
            if (hit_q.size() == 0) begin
                $error("unexpected result beat, hit=%0b", got);
                errors++;
                return;
            end
            want = hit_q.pop_front();
            if (got !== want) begin
                $error("hit mismatch: expected %0b actual %0b", want, got);
                errors++;
            end
            if (got === 1'b1) n_hits++;
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic o_stall, o_valid, o_hit;
    logic signed [31:0] ox = 0, oy = 0, oz = 0, dx = 0, dy = 0, dz = 0;
    logic signed [31:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;

    hit_board board = new();
    int  cycles;
    bit  quiet;       // no idling in the last part
    bit  hold_out;    // long receiver hold-off request

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    ray_box_slab_test DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_origin_x(ox), .i_origin_y(oy), .i_origin_z(oz),
        .i_dir_x(dx), .i_dir_y(dy), .i_dir_z(dz),
        .i_box_lo_x(ax), .i_box_lo_y(ay), .i_box_lo_z(az),
        .i_box_hi_x(bx), .i_box_hi_y(by), .i_box_hi_z(bz),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // receiver: checks beats and drives stall in bursts
    always @(posedge i_clk) begin
        int burst;
        if (i_rst_n && o_valid && !i_stall) board.check_hit(o_hit);
        if (hold_out) begin
            i_stall <= 1;
        end else if (burst > 0) begin
            burst = burst - 1;
            i_stall <= (burst > 0);
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 9);
            i_stall <= 1;
        end else begin
            i_stall <= 0;
        end
    end

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh8000_0000 + $urandom_range(0, 3);
            2: return 32'sh7fff_ffff - $urandom_range(0, 3);
            3: return $urandom_range(0, 2) - 1;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    // mostly well-formed ray: most axes aimed roughly at a box around a random centre
    function automatic t_ray make_ray();
        t_ray r;
        int unsigned c, h;
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                r.o[k] = pick_coord(); r.d[k] = pick_coord();
                r.a[k] = pick_coord(); r.b[k] = pick_coord();
            end else begin
                c = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                h = $urandom_range(1, 32'h0004_0000);
                r.a[k] = c - h;
                r.b[k] = c + h;
                if ($urandom_range(0, 1)) begin
                    r.a[k] = c + h; r.b[k] = c - h;
                end
                r.o[k] = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
                case ($urandom_range(0, 5))
                    0: r.d[k] = 0;
                    1: r.d[k] = $urandom;
                    default: r.d[k] = ($signed(c) - r.o[k]) >>> $urandom_range(0, 6);
                endcase
            end
        end
        return r;
    endfunction

    function automatic t_ray pack_ray(logic signed [31:0] o0, o1, o2, d0, d1, d2,
                                      a0, a1, a2, b0, b1, b2);
        t_ray r;
        r.o = '{o0, o1, o2}; r.d = '{d0, d1, d2};
        r.a = '{a0, a1, a2}; r.b = '{b0, b1, b2};
        return r;
    endfunction

    task automatic send_ray(t_ray r);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        ox <= r.o[0]; oy <= r.o[1]; oz <= r.o[2];
        dx <= r.d[0]; dy <= r.d[1]; dz <= r.d[2];
        ax <= r.a[0]; ay <= r.a[1]; az <= r.a[2];
        bx <= r.b[0]; by <= r.b[1]; bz <= r.b[2];
        do @(posedge i_clk); while (o_stall);
        board.note_ray(r);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.hit_q.size() != 0) @(posedge i_clk);
    endtask

    localparam logic signed [31:0] MN = 32'sh8000_0000;
    localparam logic signed [31:0] MX = 32'sh7fff_ffff;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    initial begin
        t_ray r;
        cycles = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, zero direction inside/outside, swapped corners
        send_ray(pack_ray(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_ray(pack_ray(2*ONE, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_ray(pack_ray(ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE));
        send_ray(pack_ray(-5*ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_ray(pack_ray(5*ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_ray(pack_ray(5*ONE, 0, 0, -ONE, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE));
        send_ray(pack_ray(MN, MN, MN, MX, MX, MX, MX, MX, MX, MN, MN, MN));
        send_ray(pack_ray(MX, MX, MX, MN, MN, MN, MN, MN, MN, MX, MX, MX));
        send_ray(pack_ray(MN, MX, MN, 1, -1, 1, MX, MN, MX, MX, MN, MX));
        send_ray(pack_ray(MX, MN, 0, -1, 1, 0, MN, MX, MN, MN, MX, MX));
        send_ray(pack_ray(0, 0, 0, MX, MX, MN, MN, MN, MN, MX, MX, MX));
        send_ray(pack_ray(-3*ONE, -3*ONE, -3*ONE, ONE, ONE, ONE,
                          -ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_ray(pack_ray(-3*ONE, 3*ONE, 0, ONE, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_ray(pack_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_ray(pack_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_ray(pack_ray(ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0));
        drain();

        // long hold-off: sender keeps offering until the block stalls its input
        fork
            begin
                hold_out = 1;
                repeat (60) @(posedge i_clk);
                hold_out = 0;
            end
            for (int i = 0; i < 40; i++) send_ray(make_ray());
        join
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 200) quiet = 1;
            if ($urandom_range(0, 9) < 8) begin
                r = make_ray();
            end else begin
                r = pack_ray(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                             pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                             pick_coord(), pick_coord(), pick_coord(), pick_coord());
            end
            send_ray(r);
            if (i == 500) drain();
        end
        drain();
        repeat (LATENCY * 2) @(posedge i_clk);

        $display("checked %0d ray/box beats, %0d hits, including stall and drain phases",
                 board.n_checked, board.n_hits);
        if (board.errors == 0 && board.hit_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
